// File: design/deque_with_search_remove_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the deque core
// Shared same-cycle and next-cycle implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_SEARCH_REMOVE_CORE_DEFINES_SVH
`define DEQUE_WITH_SEARCH_REMOVE_CORE_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define DQSR_ASSERT_IMP(name, clk_i, rst_i, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define DQSR_ASSERT_NXT(name, clk_i, rst_i, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/dqsr_pkg.sv
// ----------------------------------------------------------------------------
// dqsr_pkg
// Beat types, operation and status codes, and defaults for the deque core.
// ----------------------------------------------------------------------------
`default_nettype none

package dqsr_pkg;

  localparam int DQSR_DEPTH       = 16;
  localparam int DQSR_VALUE_WIDTH = 32;

  localparam int FIELD_W   = 32;
  localparam int CNT_OUT_W = 5;

  // Operation codes; code 7 behaves as a query.
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_CONTAINS   = 3'd4;
  localparam logic [2:0] OP_REMOVE     = 3'd5;
  localparam logic [2:0] OP_QUERY      = 3'd6;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]                op;
    logic signed [FIELD_W-1:0] value;
  } dqsr_req_t;

  typedef struct packed {
    logic [1:0]                status;
    logic                      found;
    logic signed [FIELD_W-1:0] front_value;
    logic signed [FIELD_W-1:0] back_value;
    logic [CNT_OUT_W-1:0]      entry_count;
    logic                      is_empty;
  } dqsr_rsp_t;

endpackage

`default_nettype wire

// File: design/dqsr_ram.sv
// ----------------------------------------------------------------------------
// dqsr_ram
// Ring storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dqsr_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/deque_with_search_remove_core.sv
// ----------------------------------------------------------------------------
// deque_with_search_remove_core
// Bounded double-ended queue of signed values with search and remove.
//
// Pulse start with a request beat while busy is low; the beat is taken at
// that edge and busy rises. The result beat appears on rsp for exactly one
// cycle with done high, and busy is low in that same cycle, so the next
// request may be taken there. There is no back-pressure on results: the
// receiver must capture rsp whenever done is high. Entries live in a ring
// memory with a single read port, and that port sets the timing. Push, pop
// and query make two reads that fetch front and back, then return the
// result. Contains and remove first scan one entry per cycle, then make
// the same two reads. A remove that hits at position i then closes the gap
// by reading each entry behind it and writing it back one position toward
// the front. The longest operation is a remove that hits the front entry
// of a full deque. Stored values are cut to VALUE_WIDTH bits and come back
// sign-extended. The store needs no clearing after reset; only counted
// entries are ever reported.
// ----------------------------------------------------------------------------
`default_nettype none
`include "deque_with_search_remove_core_defines.svh"

module deque_with_search_remove_core
  import dqsr_pkg::*;
#(
  parameter int DEPTH       = DQSR_DEPTH,
  parameter int VALUE_WIDTH = DQSR_VALUE_WIDTH
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire dqsr_req_t req,
  output logic           busy,
  output logic           done,
  output dqsr_rsp_t      rsp
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SH_RD,
    S_SH_WR,
    S_RD_FRONT,
    S_RD_BACK,
    S_FIN
  } state_t;

  // Ring position of logical entry p: wrap once, since h + p < 2*DEPTH.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h,
                                         input logic [CNT_W-1:0] p);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(h) + (CNT_W+1)'(p);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // Sign-extend a stored entry to the result field width.
  function automatic logic [FIELD_W-1:0] widen(input logic [VALUE_WIDTH-1:0] x);
    logic signed [63:0] w;
    w = 64'($signed(x));
    return w[FIELD_W-1:0];
  endfunction

  // Control state
  state_t           state;
  logic [AW-1:0]    head;
  logic [CNT_W-1:0] cnt;

  // Per-beat working registers
  logic [2:0]             op_q;
  logic [VALUE_WIDTH-1:0] key;
  logic [1:0]             status_q;
  logic                   found_q;
  logic [CNT_W-1:0]       ri;      // next scan position to read
  logic [CNT_W-1:0]       di;      // position of the data now on rdata
  logic                   dvld;    // rdata holds a scanned entry
  logic [CNT_W-1:0]       j;       // gap position during the shift
  logic [VALUE_WIDTH-1:0] front_q;

  // Memory port
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  // Decoded helpers
  logic                       accept;
  logic                       full;
  logic                       empty;
  logic [CNT_W-1:0]           cnt_m1;
  logic [CNT_W-1:0]           j_p1;
  logic [AW-1:0]              head_dec;
  logic signed [63:0]         val64;
  logic [VALUE_WIDTH-1:0]     key_in;
  logic                       hit;
  logic                       last;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign full     = (cnt == CNT_W'(DEPTH));
  assign empty    = (cnt == '0);
  assign cnt_m1   = cnt - CNT_W'(1);
  assign j_p1     = j + CNT_W'(1);
  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign val64    = 64'($signed(req.value));
  assign key_in   = val64[VALUE_WIDTH-1:0];
  assign cnt_ext  = (CNT_W+CNT_OUT_W)'(cnt);

  // Shared compare unit: one stored entry against the key per cycle.
  assign hit  = dvld && (ram_rdata == key);
  assign last = dvld && (di == cnt_m1);

  // Read address: scan, shift source, or the front and back fetch.
  always_comb begin
    unique case (state)
      S_SCAN:    ram_raddr = slot(head, ri);
      S_SH_RD:   ram_raddr = slot(head, j_p1);
      S_RD_BACK: ram_raddr = slot(head, cnt_m1);
      default:   ram_raddr = head;
    endcase
  end

  // Write port: pushes at accept, gap closing during the shift.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = head_dec;
    ram_wdata = key_in;
    if (state == S_SH_WR) begin
      ram_we    = 1'b1;
      ram_waddr = slot(head, j);
      ram_wdata = ram_rdata;
    end else if (accept && !full) begin
      if (req.op == OP_PUSH_FRONT) begin
        ram_we = 1'b1;
      end else if (req.op == OP_PUSH_BACK) begin
        ram_we    = 1'b1;
        ram_waddr = slot(head, cnt);
      end
    end
  end

  dqsr_ram #(
    .DEPTH (DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      // Raise the result strobe for one cycle, as S_FIN registers the result.
      done <= (state == S_FIN);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_q     <= req.op;
            key      <= key_in;
            found_q  <= 1'b0;
            ri       <= '0;
            di       <= '0;
            dvld     <= 1'b0;
            unique case (req.op)
              OP_PUSH_FRONT: begin
                state <= S_RD_FRONT;
                if (full) begin
                  status_q <= ST_FULL;
                end else begin
                  status_q <= ST_OK;
                  head     <= head_dec;
                  cnt      <= cnt + CNT_W'(1);
                end
              end
              OP_PUSH_BACK: begin
                state <= S_RD_FRONT;
                if (full) begin
                  status_q <= ST_FULL;
                end else begin
                  status_q <= ST_OK;
                  cnt      <= cnt + CNT_W'(1);
                end
              end
              OP_POP_FRONT: begin
                state <= S_RD_FRONT;
                if (empty) begin
                  status_q <= ST_EMPTY;
                end else begin
                  status_q <= ST_OK;
                  head     <= slot(head, CNT_W'(1));
                  cnt      <= cnt_m1;
                end
              end
              OP_POP_BACK: begin
                state <= S_RD_FRONT;
                if (empty) begin
                  status_q <= ST_EMPTY;
                end else begin
                  status_q <= ST_OK;
                  cnt      <= cnt_m1;
                end
              end
              OP_CONTAINS, OP_REMOVE: begin
                if (empty) begin
                  status_q <= ST_EMPTY;
                  state    <= S_RD_FRONT;
                end else begin
                  status_q <= ST_OK;
                  state    <= S_SCAN;
                end
              end
              default: begin
                // query and the unused code change nothing
                status_q <= ST_OK;
                state    <= S_RD_FRONT;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (hit) begin
            found_q <= 1'b1;
            j       <= di;
            if (op_q == OP_REMOVE) begin
              if (di != cnt_m1) begin
                state <= S_SH_RD;
              end else begin
                cnt   <= cnt_m1;
                state <= S_RD_FRONT;
              end
            end else begin
              state <= S_RD_FRONT;
            end
          end else if (last) begin
            if (op_q == OP_REMOVE) begin
              status_q <= ST_NOT_FOUND;
            end
            state <= S_RD_FRONT;
          end else begin
            // advance the read pointer; the compare runs in the next cycle, on the registered read data
            dvld <= (ri < cnt);
            di   <= ri;
            if (ri < cnt) begin
              ri <= ri + CNT_W'(1);
            end
          end
        end

        S_SH_RD: begin
          state <= S_SH_WR;
        end

        S_SH_WR: begin
          j <= j_p1;
          if (j_p1 != cnt_m1) begin
            state <= S_SH_RD;
          end else begin
            cnt   <= cnt_m1;
            state <= S_RD_FRONT;
          end
        end

        S_RD_FRONT: begin
          state <= S_RD_BACK;
        end

        S_RD_BACK: begin
          front_q <= ram_rdata;
          state   <= S_FIN;
        end

        S_FIN: begin
          rsp.status      <= status_q;
          rsp.found       <= found_q;
          rsp.front_value <= empty ? '0 : widen(front_q);
          rsp.back_value  <= empty ? '0 : widen(ram_rdata);
          rsp.entry_count <= cnt_ext[CNT_OUT_W-1:0];
          rsp.is_empty    <= empty;
          state           <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `DQSR_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted beat did not raise busy")
  `DQSR_ASSERT_IMP(a_done_idle, clk, rst, done, !busy, "result beat while still busy")
  `DQSR_ASSERT_IMP(a_empty_zero, clk, rst, done && rsp.is_empty, rsp.front_value == '0 && rsp.back_value == '0, "empty result with nonzero ends")
  `DQSR_ASSERT_IMP(a_found_ok, clk, rst, done && rsp.found, rsp.status == ST_OK, "match reported with error status")
  `DQSR_ASSERT_IMP(a_write_src, clk, rst, ram_we, accept || state == S_SH_WR, "store written outside push or shift")

endmodule

`default_nettype wire
